@@ rtl/pgdl_pkg.sv @@
// Shared types, codes and default sizes for the pair group dedup log unit.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package pgdl_pkg;

  // Default sizes, handed to the top level parameters
  localparam int LOOPS_DEF     = 64;
  localparam int LOG_DEPTH_DEF = 64;
  localparam int GROUP_MAX_DEF = 16;

  // Fixed field widths of the ports
  localparam int LOOP_ID_W   = 6;
  localparam int GSIZE_W     = 5;
  localparam int ID_W        = 64;
  localparam int STATUS_W    = 3;
  localparam int LOG_PAIRS_W = 6;
  localparam int STAGED_W    = 5;

  // Item kinds
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_CLOSE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_STAGE_FULL = 3'd2,
    ST_MISMATCH   = 3'd3,
    ST_LOG_FULL   = 3'd4
  } status_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DECIDE,
    B_SCAN,
    B_DRAIN,
    B_RESOLVE,
    B_COPY
  } back_state_t;

  // Classified item, as queued between front and back
  typedef struct packed {
    logic                 mode;
    logic [LOOP_ID_W-1:0] loop;
    logic [GSIZE_W-1:0]   gsize;
    logic                 bad_size;
    logic [ID_W-1:0]      first_id;
    logic [ID_W-1:0]      second_id;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/pgdl_front.sv @@
// Front end: accepts items, reduces the loop index, flags bad group sizes
// and queues the classified item in a two-entry queue. Uses pgdl_pkg.
`default_nettype none

module pgdl_front #(
  parameter int LOOPS     = pgdl_pkg::LOOPS_DEF,
  parameter int GROUP_MAX = pgdl_pkg::GROUP_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             mode,
  input  wire logic [pgdl_pkg::LOOP_ID_W-1:0]   loop_id,
  input  wire logic [pgdl_pkg::GSIZE_W-1:0]     group_size,
  input  wire logic [pgdl_pkg::ID_W-1:0]        first_id,
  input  wire logic [pgdl_pkg::ID_W-1:0]        second_id,
  input  wire logic                             hold,
  output logic                                  q_valid,
  output pgdl_pkg::item_t                       q_item,
  input  wire logic                             q_pop
);

  localparam int LOOP_CODES = 2 ** pgdl_pkg::LOOP_ID_W;

  logic [pgdl_pkg::LOOP_ID_W-1:0] loop_tbl [LOOP_CODES];
  pgdl_pkg::item_t                entry [2];
  pgdl_pkg::item_t                item_in;
  logic                           wr_ptr;
  logic                           rd_ptr;
  logic [1:0]                     fill;
  logic                           push;

  // Loop index reduction table, worked out at elaboration
  for (genvar g = 0; g < LOOP_CODES; g++) begin : g_loop_tbl
    assign loop_tbl[g] = pgdl_pkg::LOOP_ID_W'(g % LOOPS);
  end

  // Classify the incoming item
  always_comb begin
    item_in.mode      = mode;
    item_in.loop      = loop_tbl[loop_id];
    item_in.gsize     = group_size;
    item_in.bad_size  = (group_size == '0) || (32'(group_size) > GROUP_MAX);
    item_in.first_id  = first_id;
    item_in.second_id = second_id;
  end

  assign in_ready = (fill != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entry[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/pgdl_back.sv @@
// Back end: sequencer that carries out appends and closes against the
// staging buffer, the per-loop size/count store and the pair log. Uses pgdl_pkg.
`default_nettype none

module pgdl_back #(
  parameter int LOOPS     = pgdl_pkg::LOOPS_DEF,
  parameter int LOG_DEPTH = pgdl_pkg::LOG_DEPTH_DEF,
  parameter int GROUP_MAX = pgdl_pkg::GROUP_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire pgdl_pkg::item_t                  q_item,
  output logic                                  q_pop,
  output logic                                  clearing,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [pgdl_pkg::STATUS_W-1:0]         status,
  output logic                                  matched_existing,
  output logic [pgdl_pkg::LOG_PAIRS_W-1:0]      log_pairs,
  output logic [pgdl_pkg::STAGED_W-1:0]         staged_pairs
);

  localparam int LW = (LOOPS > 1) ? $clog2(LOOPS) : 1;
  localparam int DW = $clog2(LOG_DEPTH);
  localparam int GW = $clog2(GROUP_MAX + 1);
  localparam int SW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
  localparam int IW = pgdl_pkg::ID_W;
  localparam int LOG_ENTRIES = LOOPS * (2 ** DW);

  pgdl_pkg::back_state_t state, state_next;
  pgdl_pkg::item_t       cur;

  // Stores
  logic [GW-1:0]     gs_mem  [LOOPS];
  logic [DW-1:0]     cnt_mem [LOOPS];
  logic [2*IW-1:0]   log_mem [LOG_ENTRIES];
  logic [IW-1:0]     staged_first  [GROUP_MAX];
  logic [IW-1:0]     staged_second [GROUP_MAX];
  logic [GW-1:0]     staged_count;

  // Working registers
  logic [LW-1:0]     clr_idx;
  logic [GW-1:0]     gs_rd;
  logic [DW-1:0]     cnt_rd;
  logic [DW-1:0]     k;
  logic [GW-1:0]     j;
  logic [GW-1:0]     c;
  logic              cmp_vld;
  logic              cmp_last;
  logic [2*IW-1:0]   rd_data;
  logic [GROUP_MAX-1:0] hits;
  logic              matched;

  // Control from the output block
  logic              meta_re;
  logic [LW-1:0]     meta_ra;
  logic              gs_we;
  logic [LW-1:0]     gs_wa;
  logic [GW-1:0]     gs_wd;
  logic              cnt_we;
  logic [LW-1:0]     cnt_wa;
  logic [DW-1:0]     cnt_wd;
  logic              log_we;
  logic              log_re;
  logic [LW+DW-1:0]  log_wa;
  logic [LW+DW-1:0]  log_ra;
  logic              stage_we;
  logic              stage_clr;
  logic              fin;
  pgdl_pkg::status_t fin_status;
  logic              fin_matched;
  logic [DW-1:0]     fin_log;

  logic [LW-1:0]     lp;
  logic              app_full;
  logic              scan_end;
  logic              copy_end;
  logic              no_room;
  logic [DW-1:0]     cnt_sum;
  logic [GROUP_MAX-1:0] hit_vec;
  logic [GROUP_MAX-1:0] live_mask;
  logic [GROUP_MAX-1:0] hits_all;

  assign lp       = LW'(cur.loop);
  assign clearing = (state == pgdl_pkg::B_CLEAR);
  assign app_full = (32'(staged_count) >= GROUP_MAX) ||
                    (32'(staged_count) >= 32'(cur.gsize));
  assign scan_end = (k == cnt_rd - DW'(1));
  assign copy_end = (c == gs_rd - GW'(1));
  assign no_room  = (32'(cnt_rd) + 32'(gs_rd)) >= LOG_DEPTH;
  assign cnt_sum  = DW'(32'(cnt_rd) + 32'(gs_rd));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pgdl_pkg::B_CLEAR: begin
        if (clr_idx == LW'(LOOPS - 1)) begin
          state_next = pgdl_pkg::B_IDLE;
        end
      end
      pgdl_pkg::B_IDLE: begin
        if (q_valid && !out_valid) begin
          state_next = pgdl_pkg::B_DECIDE;
        end
      end
      pgdl_pkg::B_DECIDE: begin
        if (cur.mode == pgdl_pkg::MODE_CLOSE && gs_rd != '0 && staged_count == gs_rd) begin
          state_next = (cnt_rd == '0) ? pgdl_pkg::B_RESOLVE : pgdl_pkg::B_SCAN;
        end else begin
          state_next = pgdl_pkg::B_IDLE;
        end
      end
      pgdl_pkg::B_SCAN: begin
        if (scan_end) begin
          state_next = pgdl_pkg::B_DRAIN;
        end
      end
      pgdl_pkg::B_DRAIN: begin
        state_next = pgdl_pkg::B_RESOLVE;
      end
      pgdl_pkg::B_RESOLVE: begin
        state_next = (matched || no_room) ? pgdl_pkg::B_IDLE : pgdl_pkg::B_COPY;
      end
      pgdl_pkg::B_COPY: begin
        if (copy_end) begin
          state_next = pgdl_pkg::B_IDLE;
        end
      end
      default: state_next = pgdl_pkg::B_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop       = 1'b0;
    meta_re     = 1'b0;
    meta_ra     = LW'(q_item.loop);
    gs_we       = 1'b0;
    gs_wa       = lp;
    gs_wd       = GW'(cur.gsize);
    cnt_we      = 1'b0;
    cnt_wa      = lp;
    cnt_wd      = cnt_sum;
    log_we      = 1'b0;
    log_re      = 1'b0;
    log_wa      = {lp, DW'(32'(cnt_rd) + 32'(c))};
    log_ra      = {lp, k};
    stage_we    = 1'b0;
    stage_clr   = 1'b0;
    fin         = 1'b0;
    fin_status  = pgdl_pkg::ST_OK;
    fin_matched = 1'b0;
    fin_log     = cnt_rd;
    case (state)
      pgdl_pkg::B_CLEAR: begin
        gs_we  = 1'b1;
        gs_wa  = clr_idx;
        gs_wd  = '0;
        cnt_we = 1'b1;
        cnt_wa = clr_idx;
        cnt_wd = '0;
      end
      pgdl_pkg::B_IDLE: begin
        if (q_valid && !out_valid) begin
          q_pop   = 1'b1;
          meta_re = 1'b1;
        end
      end
      pgdl_pkg::B_DECIDE: begin
        if (cur.mode == pgdl_pkg::MODE_APPEND) begin
          fin = 1'b1;
          if (cur.bad_size) begin
            fin_status = pgdl_pkg::ST_BAD_SIZE;
          end else if (app_full) begin
            fin_status = pgdl_pkg::ST_STAGE_FULL;
          end else begin
            stage_we = 1'b1;
            gs_we    = (gs_rd == '0);
          end
        end else if (gs_rd == '0) begin
          fin        = 1'b1;
          stage_clr  = 1'b1;
          fin_status = pgdl_pkg::ST_BAD_SIZE;
        end else if (staged_count != gs_rd) begin
          fin        = 1'b1;
          stage_clr  = 1'b1;
          fin_status = pgdl_pkg::ST_MISMATCH;
        end
      end
      pgdl_pkg::B_SCAN: begin
        log_re = 1'b1;
      end
      pgdl_pkg::B_RESOLVE: begin
        if (matched) begin
          fin         = 1'b1;
          stage_clr   = 1'b1;
          fin_matched = 1'b1;
        end else if (no_room) begin
          fin        = 1'b1;
          stage_clr  = 1'b1;
          fin_status = pgdl_pkg::ST_LOG_FULL;
        end
      end
      pgdl_pkg::B_COPY: begin
        log_we = 1'b1;
        if (copy_end) begin
          fin       = 1'b1;
          stage_clr = 1'b1;
          cnt_we    = 1'b1;
          fin_log   = cnt_sum;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Compare one stored pair against every staged pair, either order
  always_comb begin
    for (int s = 0; s < GROUP_MAX; s++) begin
      hit_vec[s] = ((staged_first[s] == rd_data[2*IW-1:IW]) &&
                    (staged_second[s] == rd_data[IW-1:0])) ||
                   ((staged_first[s] == rd_data[IW-1:0]) &&
                    (staged_second[s] == rd_data[2*IW-1:IW]));
      live_mask[s] = (GW'(s) < staged_count);
    end
    hits_all = hits | hit_vec | ~live_mask;
  end

  // Size and count store, one read and one write port each
  always_ff @(posedge clk) begin
    if (gs_we) begin
      gs_mem[gs_wa] <= gs_wd;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (meta_re) begin
      gs_rd  <= gs_mem[meta_ra];
      cnt_rd <= cnt_mem[meta_ra];
    end
  end

  // Pair log
  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_wa] <= {staged_first[c[SW-1:0]], staged_second[c[SW-1:0]]};
    end
    if (log_re) begin
      rd_data <= log_mem[log_ra];
    end
  end

  // Staging buffer payload
  always_ff @(posedge clk) begin
    if (stage_we) begin
      staged_first[staged_count[SW-1:0]]  <= cur.first_id;
      staged_second[staged_count[SW-1:0]] <= cur.second_id;
    end
  end

  // Item, counters and scan bookkeeping
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    case (state)
      pgdl_pkg::B_DECIDE: begin
        k <= '0;
        j <= '0;
      end
      pgdl_pkg::B_SCAN: begin
        k <= k + DW'(1);
        j <= (j == gs_rd - GW'(1)) ? '0 : j + GW'(1);
      end
      pgdl_pkg::B_RESOLVE: begin
        c <= '0;
      end
      pgdl_pkg::B_COPY: begin
        c <= c + GW'(1);
      end
      default: begin
        c <= c;
      end
    endcase
    cmp_last <= (j == gs_rd - GW'(1));
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pgdl_pkg::B_CLEAR;
      clr_idx      <= '0;
      staged_count <= '0;
      cmp_vld      <= 1'b0;
      hits         <= '0;
      matched      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pgdl_pkg::B_CLEAR) begin
        clr_idx <= clr_idx + LW'(1);
      end
      if (stage_clr) begin
        staged_count <= '0;
      end else if (stage_we) begin
        staged_count <= staged_count + GW'(1);
      end
      cmp_vld <= (state == pgdl_pkg::B_SCAN);
      if (state == pgdl_pkg::B_DECIDE) begin
        hits    <= '0;
        matched <= 1'b0;
      end else if (cmp_vld) begin
        if (cmp_last) begin
          hits <= '0;
          if (&hits_all) begin
            matched <= 1'b1;
          end
        end else begin
          hits <= hits | hit_vec;
        end
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fin) begin
      status           <= fin_status;
      matched_existing <= fin_matched;
      log_pairs        <= pgdl_pkg::LOG_PAIRS_W'(fin_log);
      staged_pairs     <= stage_clr ? '0
                        : pgdl_pkg::STAGED_W'(32'(staged_count) + 32'(stage_we));
    end
  end

endmodule

`default_nettype wire

@@ rtl/pair_group_dedup_log_unit.sv @@
// Top level of the pair group dedup log unit: front end queue and back end
// sequencer. Uses pgdl_pkg, pgdl_front and pgdl_back.
//
// After reset the unit clears its per-loop size and count store, one loop per
// cycle, with in_ready low. Items then queue in a two-entry front queue and are
// carried out one at a time by the back end. An append passes through the pop
// and the decision before its result is registered. A close passes through the
// pop and the decision (where a bad size or a count mismatch ends it), then, if
// pairs are stored for that loop, a scan and a drain (the scan reads one stored
// pair per cycle from the log memory, each compared against all staged pairs
// at once), then a resolve step (where a match or a full log ends it) and, for
// a new group, a copy into the log, one pair per cycle. A result waits in an
// output register; the back end starts the next item once it is taken.
`default_nettype none

module pair_group_dedup_log_unit #(
  parameter int LOOPS     = pgdl_pkg::LOOPS_DEF,
  parameter int LOG_DEPTH = pgdl_pkg::LOG_DEPTH_DEF,
  parameter int GROUP_MAX = pgdl_pkg::GROUP_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             mode,
  input  wire logic [pgdl_pkg::LOOP_ID_W-1:0]   loop_id,
  input  wire logic [pgdl_pkg::GSIZE_W-1:0]     group_size,
  input  wire logic [pgdl_pkg::ID_W-1:0]        first_id,
  input  wire logic [pgdl_pkg::ID_W-1:0]        second_id,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [pgdl_pkg::STATUS_W-1:0]         status,
  output logic                                  matched_existing,
  output logic [pgdl_pkg::LOG_PAIRS_W-1:0]      log_pairs,
  output logic [pgdl_pkg::STAGED_W-1:0]         staged_pairs
);

  logic            q_valid;
  pgdl_pkg::item_t q_item;
  logic            q_pop;
  logic            clearing;

  // Accept and classify
  pgdl_front #(
    .LOOPS     (LOOPS),
    .GROUP_MAX (GROUP_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .loop_id    (loop_id),
    .group_size (group_size),
    .first_id   (first_id),
    .second_id  (second_id),
    .hold       (clearing),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Carry out
  pgdl_back #(
    .LOOPS     (LOOPS),
    .LOG_DEPTH (LOG_DEPTH),
    .GROUP_MAX (GROUP_MAX)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .matched_existing (matched_existing),
    .log_pairs        (log_pairs),
    .staged_pairs     (staged_pairs)
  );

endmodule

`default_nettype wire

@@ rtl/pgdl_check.sv @@
// Port-level checker for the pair group dedup log unit, bound to the top level.
// Uses pgdl_pkg status codes.
`default_nettype none

module pgdl_check (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [pgdl_pkg::STATUS_W-1:0]    status,
  input wire logic                             matched_existing,
  input wire logic [pgdl_pkg::STAGED_W-1:0]    staged_pairs
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(staged_pairs))
    else $error("result dropped or changed while stalled");

  // A match is only reported with an ok status and an emptied staging buffer
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched_existing |->
      status == pgdl_pkg::ST_OK && staged_pairs == '0)
    else $error("match reported with bad status or staged pairs left");

  // A close rejected for a mismatch or a full log empties the staging buffer
  a_close_empties: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pgdl_pkg::ST_MISMATCH || status == pgdl_pkg::ST_LOG_FULL) |->
      staged_pairs == '0)
    else $error("failed close left staged pairs");

  // Staging can only be full when it holds pairs
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == pgdl_pkg::ST_STAGE_FULL |-> staged_pairs != '0)
    else $error("staging full reported with empty staging");

endmodule

bind pair_group_dedup_log_unit pgdl_check u_pgdl_check (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .status           (status),
  .matched_existing (matched_existing),
  .staged_pairs     (staged_pairs)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for pair_group_dedup_log_unit: directed table then random items,
// each result checked against an in-bench model of the group dedup log.
// Depends on pgdl_pkg and the RTL top level.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLOOPS = 64;
  localparam int DEPTH  = 64;
  localparam int GMAX   = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = pgdl_pkg::MODE_APPEND;
  logic [pgdl_pkg::LOOP_ID_W-1:0] loop_id = '0;
  logic [pgdl_pkg::GSIZE_W-1:0] group_size = '0;
  logic [pgdl_pkg::ID_W-1:0] first_id = '0;
  logic [pgdl_pkg::ID_W-1:0] second_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pgdl_pkg::STATUS_W-1:0] status;
  logic matched_existing;
  logic [pgdl_pkg::LOG_PAIRS_W-1:0] log_pairs;
  logic [pgdl_pkg::STAGED_W-1:0] staged_pairs;

  pair_group_dedup_log_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .loop_id(loop_id), .group_size(group_size),
    .first_id(first_id), .second_id(second_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .matched_existing(matched_existing),
    .log_pairs(log_pairs), .staged_pairs(staged_pairs)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic                             mode;
    logic [pgdl_pkg::LOOP_ID_W-1:0]   loop;
    logic [pgdl_pkg::GSIZE_W-1:0]     gsize;
    logic [pgdl_pkg::ID_W-1:0]        a;
    logic [pgdl_pkg::ID_W-1:0]        b;
  } pair_item_t;

  typedef struct packed {
    pgdl_pkg::status_t                st;
    logic                             hit;
    logic [pgdl_pkg::LOG_PAIRS_W-1:0] lp;
    logic [pgdl_pkg::STAGED_W-1:0]    sp;
  } outcome_t;

  // Model state of the log
  logic [pgdl_pkg::ID_W-1:0] stage_a [GMAX];
  logic [pgdl_pkg::ID_W-1:0] stage_b [GMAX];
  int unsigned               stage_n;
  int unsigned               loop_size [NLOOPS];
  logic [pgdl_pkg::ID_W-1:0] log_a [NLOOPS][DEPTH];
  logic [pgdl_pkg::ID_W-1:0] log_b [NLOOPS][DEPTH];
  int unsigned               log_n [NLOOPS];

  outcome_t expected_outcomes[$];
  int   errors = 0;
  bit   quiet_phase = 1'b0;
  bit   long_hold = 1'b0;

  // Apply one item to the model log and return its outcome
  function automatic outcome_t dedup_outcome(pair_item_t it);
    outcome_t r;
    int unsigned lp, sz, cnt, base, s, k;
    bit hit, found;
    r.st = pgdl_pkg::ST_OK;
    r.hit = 1'b0;
    lp = it.loop % NLOOPS;
    if (it.mode == pgdl_pkg::MODE_APPEND) begin
      if (it.gsize == 0 || it.gsize > GMAX) begin
        r.st = pgdl_pkg::ST_BAD_SIZE;
      end else if (stage_n >= GMAX || stage_n >= it.gsize) begin
        r.st = pgdl_pkg::ST_STAGE_FULL;
      end else begin
        if (loop_size[lp] == 0) loop_size[lp] = it.gsize;
        stage_a[stage_n] = it.a;
        stage_b[stage_n] = it.b;
        stage_n++;
      end
    end else begin
      sz = loop_size[lp];
      if (sz == 0) begin
        r.st = pgdl_pkg::ST_BAD_SIZE;
      end else if (stage_n != sz) begin
        r.st = pgdl_pkg::ST_MISMATCH;
      end else begin
        cnt = log_n[lp];
        for (base = 0; base + sz <= cnt && !r.hit; base += sz) begin
          found = 1'b1;
          for (s = 0; s < sz; s++) begin
            hit = 1'b0;
            for (k = base; k < base + sz; k++)
              if ((stage_a[s] == log_a[lp][k] && stage_b[s] == log_b[lp][k]) ||
                  (stage_a[s] == log_b[lp][k] && stage_b[s] == log_a[lp][k]))
                hit = 1'b1;
            if (!hit) found = 1'b0;
          end
          if (found) r.hit = 1'b1;
        end
        if (!r.hit) begin
          if (cnt + sz >= DEPTH) begin
            r.st = pgdl_pkg::ST_LOG_FULL;
          end else begin
            for (s = 0; s < sz; s++) begin
              log_a[lp][cnt + s] = stage_a[s];
              log_b[lp][cnt + s] = stage_b[s];
            end
            log_n[lp] = cnt + sz;
          end
        end
      end
      stage_n = 0;
    end
    r.lp = log_n[lp][pgdl_pkg::LOG_PAIRS_W-1:0];
    r.sp = stage_n[pgdl_pkg::STAGED_W-1:0];
    return r;
  endfunction

  // Offer one item, hold it until transferred, then record the expectation
  task automatic send_item(pair_item_t it, bit check_row, outcome_t row);
    outcome_t p;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= it.mode;
    loop_id    <= it.loop;
    group_size <= it.gsize;
    first_id   <= it.a;
    second_id  <= it.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = dedup_outcome(it);
    if (check_row && p != row) begin
      $error("directed row differs from model: row %p model %p", row, p);
      errors++;
    end
    expected_outcomes.push_back(check_row ? row : p);
    @(negedge clk);
  endtask

  function automatic pair_item_t mk(logic m, int lp, int gs, logic [63:0] a, logic [63:0] b);
    pair_item_t it;
    it.mode = m;
    it.loop = lp[pgdl_pkg::LOOP_ID_W-1:0];
    it.gsize = gs[pgdl_pkg::GSIZE_W-1:0];
    it.a = a;
    it.b = b;
    return it;
  endfunction

  function automatic outcome_t oc(pgdl_pkg::status_t s, logic h, int lp, int sp);
    outcome_t r;
    r.st = s;
    r.hit = h;
    r.lp = lp[pgdl_pkg::LOG_PAIRS_W-1:0];
    r.sp = sp[pgdl_pkg::STAGED_W-1:0];
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed table: item, whether the expectation is typed in, and that expectation
  typedef struct {
    pair_item_t it;
    bit         typed;
    outcome_t   want;
  } row_t;

  row_t dir_rows[$];

  // Take results and compare against the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with nothing expected: status %0d", status);
        errors++;
      end else begin
        e = expected_outcomes.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d actual %0d", e.st, status); errors++;
        end
        if (matched_existing !== e.hit) begin
          $error("matched_existing: expected %0d actual %0d", e.hit, matched_existing);
          errors++;
        end
        if (log_pairs !== e.lp) begin
          $error("log_pairs: expected %0d actual %0d", e.lp, log_pairs); errors++;
        end
        if (staged_pairs !== e.sp) begin
          $error("staged_pairs: expected %0d actual %0d", e.sp, staged_pairs); errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, long hold-offs while long_hold is set, none at the end
  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus
  initial begin
    pair_item_t it;
    logic [63:0] ga [GMAX];
    logic [63:0] gb [GMAX];
    int n, lp, gs, i, k, drain;
    stage_n = 0;
    foreach (loop_size[j]) begin
      loop_size[j] = 0;
      log_n[j] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes, the bad size, stage full and mismatch codes, match in swapped order, and a full staging buffer
    dir_rows.push_back('{mk(pgdl_pkg::MODE_CLOSE, 5, 0, 0, 0), 1,
                         oc(pgdl_pkg::ST_BAD_SIZE, 0, 0, 0)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 0, 1, 2), 1,
                         oc(pgdl_pkg::ST_BAD_SIZE, 0, 0, 0)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 17, 1, 2), 1,
                         oc(pgdl_pkg::ST_BAD_SIZE, 0, 0, 0)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 31, 1, 2), 1,
                         oc(pgdl_pkg::ST_BAD_SIZE, 0, 0, 0)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 2, '1, 0), 1,
                         oc(pgdl_pkg::ST_OK, 0, 0, 1)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 9, 7, 8), 1,
                         oc(pgdl_pkg::ST_OK, 0, 0, 2)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 2, 3, 4), 1,
                         oc(pgdl_pkg::ST_STAGE_FULL, 0, 0, 2)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_CLOSE, 5, 0, 0, 0), 1,
                         oc(pgdl_pkg::ST_OK, 0, 2, 0)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 2, 8, 7), 1,
                         oc(pgdl_pkg::ST_OK, 0, 2, 1)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 2, 0, '1), 1,
                         oc(pgdl_pkg::ST_OK, 0, 2, 2)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_CLOSE, 5, 0, 0, 0), 1,
                         oc(pgdl_pkg::ST_OK, 1, 2, 0)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 5, 2, 1, 1), 1,
                         oc(pgdl_pkg::ST_OK, 0, 2, 1)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_CLOSE, 5, 0, 0, 0), 1,
                         oc(pgdl_pkg::ST_MISMATCH, 0, 2, 0)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 63, 16, '1, '1), 1,
                         oc(pgdl_pkg::ST_OK, 0, 0, 1)});
    for (i = 0; i < 15; i++)
      dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 63, 16, i,
                              64'h8000_0000_0000_0000 | i), 0, '0});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_APPEND, 63, 16, 1, 1), 1,
                         oc(pgdl_pkg::ST_STAGE_FULL, 0, 0, 16)});
    dir_rows.push_back('{mk(pgdl_pkg::MODE_CLOSE, 63, 0, 0, 0), 1,
                         oc(pgdl_pkg::ST_OK, 0, 16, 0)});
    foreach (dir_rows[r]) send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);

    // Random part: mostly well-formed groups, often repeating a stored group
    n = 0;
    while (n < 900) begin
      lp = (n < 300) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      if ($urandom_range(0, 9) == 0) begin
        it = mk(1'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 31),
                rnd64(), rnd64());
        send_item(it, 0, '0);
        n++;
      end else begin
        gs = (loop_size[lp % NLOOPS] != 0) ? loop_size[lp % NLOOPS]
             : ($urandom_range(0, 3) == 0 ? $urandom_range(5, 16) : $urandom_range(1, 4));
        if (log_n[lp] >= gs && $urandom_range(0, 1)) begin
          k = gs * $urandom_range(0, log_n[lp] / gs - 1);
          for (i = 0; i < gs; i++) begin
            ga[i] = log_a[lp][k + gs - 1 - i];
            gb[i] = log_b[lp][k + gs - 1 - i];
            if ($urandom_range(0, 1)) {ga[i], gb[i]} = {gb[i], ga[i]};
          end
          if ($urandom_range(0, 5) == 0) ga[0] = ga[0] ^ (64'd1 << $urandom_range(0, 63));
        end else begin
          for (i = 0; i < gs; i++) begin
            ga[i] = $urandom_range(0, 2) == 0 ? rnd64() : $urandom_range(0, 5);
            gb[i] = $urandom_range(0, 2) == 0 ? rnd64() : $urandom_range(0, 5);
          end
        end
        k = gs + ($urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : 0) -
            ($urandom_range(0, 7) == 0 ? 1 : 0);
        for (i = 0; i < k && i < GMAX; i++) begin
          send_item(mk(pgdl_pkg::MODE_APPEND, lp,
                       $urandom_range(0, 7) == 0 ? $urandom_range(1, 16) : gs,
                       ga[i % gs], gb[i % gs]), 0, '0);
          n++;
        end
        if (n > 400 && n < 440) long_hold = 1'b1;
        send_item(mk(pgdl_pkg::MODE_CLOSE, lp, $urandom_range(0, 31), rnd64(), rnd64()),
                  0, '0);
        n++;
      end
      if (n > 820) quiet_phase = 1'b1;
    end
    in_valid <= 1'b0;

    drain = 0;
    while (expected_outcomes.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", expected_outcomes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
